// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TTCS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent at one edge, consequent at the next.
`define TTCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ttcs_pkg.sv -----
`default_nettype none

package ttcs_pkg;

   // screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int CELLS     = ROWS * COLUMNS;
   localparam int ROW_LIMIT = 2 * ROWS - 1;
   localparam int TAB_STEP  = 8;

   localparam int ADDR_W    = $clog2(CELLS);
   localparam int ROW_POS_W = $clog2(2 * ROWS);
   localparam int COL_POS_W = $clog2(COLUMNS + 1);
   localparam int ROW_IDX_W = $clog2(ROWS);
   localparam int COL_IDX_W = $clog2(COLUMNS);
   localparam int SCR_W     = $clog2(ROWS + 1);

   // op queue between front and back
   localparam int OPQ_DEPTH = 2;
   localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
   localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

   // fixed port field widths
   localparam int CELL_ROW_W = 5;
   localparam int CELL_COL_W = 7;
   localparam int SCROLL_W   = 5;
   localparam int CUR_ROW_W  = 6;
   localparam int CUR_COL_W  = 7;

   localparam logic [7:0]  CHAR_SPACE       = 8'h20;
   localparam logic [7:0]  CHAR_NEWLINE     = 8'h0A;
   localparam logic [7:0]  CHAR_TAB         = 8'h09;
   localparam logic [7:0]  TEXT_COLOR_RESET = 8'h07;
   localparam logic [15:0] CELL_RESET       = 16'h0720;

   // commands
   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic                  cell_written;
      logic [CELL_ROW_W-1:0] cell_row;
      logic [CELL_COL_W-1:0] cell_col;
      logic [15:0]           cell_value;
      logic [SCROLL_W-1:0]   rows_scrolled;
      logic [CUR_ROW_W-1:0]  cursor_row;
      logic [CUR_COL_W-1:0]  cursor_col;
      logic [15:0]           read_value;
   } rsp_type;

   // classified work for the back end
   typedef struct packed {
      logic                 write;
      logic [ROW_IDX_W-1:0] wrow;
      logic [COL_IDX_W-1:0] wcol;
      logic [7:0]           wchar;
      logic [SCR_W-1:0]     scroll;
      logic [ROW_POS_W-1:0] cursor_row;
      logic [COL_POS_W-1:0] cursor_col;
      logic                 rd;
      logic [ADDR_W-1:0]    rd_addr;
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_FILL,
      ST_EXEC,
      ST_RDWAIT
   } back_state_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] row,
                                                   input logic [COL_IDX_W-1:0] col);
      return ADDR_W'(int'(row) * COLUMNS + int'(col));
   endfunction

endpackage

`default_nettype wire

// ----- hdl/ttcs_op_queue.sv -----
`default_nettype none

module ttcs_op_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  ttcs_pkg::op_type      push_data,
   input  wire logic             pop,
   output ttcs_pkg::op_type      pop_data,
   output logic                  full,
   output logic                  empty
);

   ttcs_pkg::op_type                 slot_ff [ttcs_pkg::OPQ_DEPTH];
   logic [ttcs_pkg::OPQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ttcs_pkg::OPQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ttcs_pkg::OPQ_CNT_W-1:0]   count_ff, count_in;
   logic                             do_push, do_pop;

   assign full     = (count_ff == ttcs_pkg::OPQ_CNT_W'(ttcs_pkg::OPQ_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ttcs_pkg::OPQ_PTR_W'(ttcs_pkg::OPQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ttcs_pkg::OPQ_PTR_W'(ttcs_pkg::OPQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ttcs_front.sv -----
`default_nettype none

// Cursor tracking and command classification; one item per cycle while accept is high.
module ttcs_front (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  ttcs_pkg::req_type  req,
   output ttcs_pkg::op_type   op
);

   logic [ttcs_pkg::ROW_POS_W-1:0] row_ff, row_in;
   logic [ttcs_pkg::COL_POS_W-1:0] col_ff, col_in;

   logic [ttcs_pkg::ROW_POS_W-1:0] row_adv;
   logic                           wrap;
   logic [ttcs_pkg::COL_POS_W:0]   tab_base, tab_sum;
   logic [ttcs_pkg::COL_POS_W-1:0] tab_col;
   logic [ttcs_pkg::COL_POS_W-1:0] pr_col;
   logic [ttcs_pkg::ROW_POS_W-1:0] pr_row, excess, wrow_full;
   logic                           over;
   logic [ttcs_pkg::SCR_W-1:0]     scroll_n;

   always_comb begin
      row_adv  = (row_ff < ttcs_pkg::ROW_POS_W'(ttcs_pkg::ROW_LIMIT)) ? row_ff + 1'b1 : row_ff;
      wrap     = (col_ff >= ttcs_pkg::COL_POS_W'(ttcs_pkg::COLUMNS));

      // next tab stop, clamped at the right edge
      tab_base = {1'b0, col_ff} & ~((ttcs_pkg::COL_POS_W + 1)'(ttcs_pkg::TAB_STEP - 1));
      tab_sum  = tab_base + (ttcs_pkg::COL_POS_W + 1)'(ttcs_pkg::TAB_STEP);
      tab_col  = (tab_sum > (ttcs_pkg::COL_POS_W + 1)'(ttcs_pkg::COLUMNS)) ?
                 ttcs_pkg::COL_POS_W'(ttcs_pkg::COLUMNS) : tab_sum[ttcs_pkg::COL_POS_W-1:0];

      // printable: wrap, then scroll if below the bottom row
      pr_col    = wrap ? '0 : col_ff;
      pr_row    = wrap ? row_adv : row_ff;
      over      = (pr_row >= ttcs_pkg::ROW_POS_W'(ttcs_pkg::ROWS));
      excess    = pr_row - ttcs_pkg::ROW_POS_W'(ttcs_pkg::ROWS - 1);
      scroll_n  = (excess > ttcs_pkg::ROW_POS_W'(ttcs_pkg::ROWS)) ?
                  ttcs_pkg::SCR_W'(ttcs_pkg::ROWS) : ttcs_pkg::SCR_W'(excess);
      wrow_full = over ? ttcs_pkg::ROW_POS_W'(ttcs_pkg::ROWS - 1) : pr_row;

      op     = '0;
      row_in = row_ff;
      col_in = col_ff;
      case (req.cmd)
         ttcs_pkg::CMD_PUT: begin
            if (req.char_code == ttcs_pkg::CHAR_NEWLINE) begin
               col_in = '0;
               row_in = row_adv;
            end else if (req.char_code == ttcs_pkg::CHAR_TAB) begin
               col_in = tab_col;
            end else begin
               op.write  = 1'b1;
               op.wrow   = ttcs_pkg::ROW_IDX_W'(wrow_full);
               op.wcol   = ttcs_pkg::COL_IDX_W'(pr_col);
               op.wchar  = req.char_code;
               op.scroll = over ? scroll_n : '0;
               row_in    = wrow_full;
               col_in    = pr_col + 1'b1;
            end
         end
         ttcs_pkg::CMD_CLEAR: begin
            op.scroll = ttcs_pkg::SCR_W'(ttcs_pkg::ROWS);
         end
         ttcs_pkg::CMD_READ: begin
            op.rd      = (int'(req.read_row) < ttcs_pkg::ROWS) &&
                         (int'(req.read_col) < ttcs_pkg::COLUMNS);
            op.rd_addr = ttcs_pkg::cell_addr(ttcs_pkg::ROW_IDX_W'(req.read_row),
                                             ttcs_pkg::COL_IDX_W'(req.read_col));
         end
         default: begin
         end
      endcase
      op.cursor_row = row_in;
      op.cursor_col = col_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/ttcs_back.sv -----
`default_nettype none

// Store sequencer: clearing pass, scroll copy and fill, cell write or read.
module ttcs_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [7:0]    text_color,
   input  wire logic          op_empty,
   input  ttcs_pkg::op_type   op_head,
   output logic               op_pop,
   input  wire logic          rsp_take,
   output logic               rsp_valid,
   output ttcs_pkg::rsp_type  rsp,
   output logic               clearing
);

   ttcs_pkg::back_state_type      state_ff, state_in;
   ttcs_pkg::op_type              op_ff, op_in;
   logic [ttcs_pkg::ADDR_W-1:0]   idx_ff, idx_in;
   logic [ttcs_pkg::ADDR_W-1:0]   copy_end_ff, copy_end_in;
   logic [ttcs_pkg::ADDR_W-1:0]   offset_ff, offset_in;
   logic [ttcs_pkg::ADDR_W-1:0]   copy_end_head, offset_head;

   // writes are registered before they reach the store
   logic                          wr_en_ff, wr_en_in;
   logic                          wr_from_rd_ff, wr_from_rd_in;
   logic [ttcs_pkg::ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic [15:0]                   wr_data_ff, wr_data_in;
   logic [ttcs_pkg::ADDR_W-1:0]   rd_addr;
   logic [15:0]                   rd_data_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   ttcs_pkg::rsp_type             rsp_ff, rsp_in;
   logic                          load;
   logic                          take;

   logic [15:0]                   screen_mem [ttcs_pkg::CELLS];

   assign take          = (state_ff == ttcs_pkg::ST_IDLE) && !op_empty &&
                          (!rsp_valid_ff || rsp_take);
   assign copy_end_head = ttcs_pkg::ADDR_W'((ttcs_pkg::ROWS - int'(op_head.scroll)) *
                                            ttcs_pkg::COLUMNS);
   assign offset_head   = ttcs_pkg::ADDR_W'(int'(op_head.scroll) * ttcs_pkg::COLUMNS);

   assign op_pop    = take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign clearing  = (state_ff == ttcs_pkg::ST_CLEAR);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ttcs_pkg::ST_CLEAR: begin
            if (idx_ff == ttcs_pkg::ADDR_W'(ttcs_pkg::CELLS - 1)) state_in = ttcs_pkg::ST_IDLE;
         end
         ttcs_pkg::ST_IDLE: begin
            if (take) begin
               if (op_head.scroll == '0) begin
                  state_in = ttcs_pkg::ST_EXEC;
               end else if (copy_end_head == '0) begin
                  state_in = ttcs_pkg::ST_FILL;
               end else begin
                  state_in = ttcs_pkg::ST_COPY;
               end
            end
         end
         ttcs_pkg::ST_COPY: begin
            if (idx_ff == copy_end_ff - 1'b1) state_in = ttcs_pkg::ST_FILL;
         end
         ttcs_pkg::ST_FILL: begin
            if (idx_ff == ttcs_pkg::ADDR_W'(ttcs_pkg::CELLS - 1)) state_in = ttcs_pkg::ST_EXEC;
         end
         ttcs_pkg::ST_EXEC: begin
            state_in = op_ff.rd ? ttcs_pkg::ST_RDWAIT : ttcs_pkg::ST_IDLE;
         end
         ttcs_pkg::ST_RDWAIT: begin
            state_in = ttcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttcs_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      op_in         = op_ff;
      idx_in        = idx_ff;
      copy_end_in   = copy_end_ff;
      offset_in     = offset_ff;
      wr_en_in      = 1'b0;
      wr_from_rd_in = 1'b0;
      wr_addr_in    = wr_addr_ff;
      wr_data_in    = wr_data_ff;
      rd_addr       = '0;
      load          = 1'b0;
      case (state_ff)
         ttcs_pkg::ST_CLEAR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = idx_ff;
            wr_data_in = ttcs_pkg::CELL_RESET;
            idx_in     = idx_ff + 1'b1;
         end
         ttcs_pkg::ST_IDLE: begin
            if (take) begin
               op_in       = op_head;
               idx_in      = '0;
               copy_end_in = copy_end_head;
               offset_in   = offset_head;
            end
         end
         ttcs_pkg::ST_COPY: begin
            rd_addr       = idx_ff + offset_ff;
            wr_en_in      = 1'b1;
            wr_from_rd_in = 1'b1;
            wr_addr_in    = idx_ff;
            idx_in        = idx_ff + 1'b1;
         end
         ttcs_pkg::ST_FILL: begin
            wr_en_in   = 1'b1;
            wr_addr_in = idx_ff;
            wr_data_in = {text_color, ttcs_pkg::CHAR_SPACE};
            idx_in     = idx_ff + 1'b1;
         end
         ttcs_pkg::ST_EXEC: begin
            if (op_ff.write) begin
               wr_en_in   = 1'b1;
               wr_addr_in = ttcs_pkg::cell_addr(op_ff.wrow, op_ff.wcol);
               wr_data_in = {text_color, op_ff.wchar};
            end
            rd_addr = op_ff.rd_addr;
            load    = !op_ff.rd;
         end
         ttcs_pkg::ST_RDWAIT: begin
            load = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in.cell_written  = op_ff.write;
      rsp_in.cell_row      = ttcs_pkg::CELL_ROW_W'(op_ff.wrow);
      rsp_in.cell_col      = ttcs_pkg::CELL_COL_W'(op_ff.wcol);
      rsp_in.cell_value    = op_ff.write ? {text_color, op_ff.wchar} : 16'h0000;
      rsp_in.rows_scrolled = ttcs_pkg::SCROLL_W'(op_ff.scroll);
      rsp_in.cursor_row    = ttcs_pkg::CUR_ROW_W'(op_ff.cursor_row);
      rsp_in.cursor_col    = ttcs_pkg::CUR_COL_W'(op_ff.cursor_col);
      rsp_in.read_value    = (state_ff == ttcs_pkg::ST_RDWAIT) ? rd_data_ff : 16'h0000;

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttcs_pkg::ST_CLEAR;
         idx_ff       <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      copy_end_ff   <= copy_end_in;
      offset_ff     <= offset_in;
      wr_from_rd_ff <= wr_from_rd_in;
      wr_addr_ff    <= wr_addr_in;
      wr_data_ff    <= wr_data_in;
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // cell store: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         screen_mem[wr_addr_ff] <= wr_from_rd_ff ? rd_data_ff : wr_data_ff;
      end
      rd_data_ff <= screen_mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hdl/text_terminal_cursor_scroll.sv -----
// Channel   Ports                        Beat moves on
// input     req_push/req_full/req_data   push high, full low
// result    rsp_pop/rsp_empty/rsp_data   pop high, empty low
// config    csr_wr_en/csr_wr_data        write enable high
//
// A put without scroll, newline, tab or unused command passes through the
// exec state of the back end; a read adds a wait state (registered store read).
// A scroll or clear first rewrites the store one cell per cycle (copy, then fill).
// After reset the store is swept to space-on-grey with req_full high. The
// front accepts a beat per cycle, while req_full is low, into a two-deep op
// queue, so input and result sides stall independently.
`default_nettype none

`include "assert_macros.svh"

module text_terminal_cursor_scroll (
   input  wire logic          clock,
   input  wire logic          reset,
   // input channel
   input  wire logic          req_push,
   output logic               req_full,
   input  ttcs_pkg::req_type  req_data,
   // result channel
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output ttcs_pkg::rsp_type  rsp_data,
   // text colour register
   input  wire logic          csr_wr_en,
   input  wire logic [7:0]    csr_wr_data
);

   logic [7:0]        text_color_ff, text_color_in;
   logic              accept;
   logic              rsp_take;
   logic              rsp_valid;
   logic              clearing;

   ttcs_pkg::op_type  front_op;
   ttcs_pkg::op_type  queue_head;
   logic              queue_full, queue_empty, queue_pop;

   // hold input off while full or during the clearing sweep
   assign req_full  = queue_full || clearing;
   assign accept    = req_push && !req_full;
   assign rsp_empty = !rsp_valid;
   assign rsp_take  = rsp_pop && rsp_valid;

   assign text_color_in = csr_wr_en ? csr_wr_data : text_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= ttcs_pkg::TEXT_COLOR_RESET;
      end else begin
         text_color_ff <= text_color_in;
      end
   end

   // front: cursor arithmetic and classification
   ttcs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .op     (front_op)
   );

   // decouples the front from long scrolls in the back
   ttcs_op_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (front_op),
      .pop       (queue_pop),
      .pop_data  (queue_head),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // back: store sweep, copy, fill, write, read and result register
   ttcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .text_color (text_color_ff),
      .op_empty   (queue_empty),
      .op_head    (queue_head),
      .op_pop     (queue_pop),
      .rsp_take   (rsp_take),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp_data),
      .clearing   (clearing)
   );

   localparam logic [ttcs_pkg::CELL_ROW_W-1:0] BOTTOM_ROW =
      ttcs_pkg::CELL_ROW_W'(ttcs_pkg::ROWS - 1);

   // the reset sweep runs once only
   `TTCS_ASSERT_NEXT(a_sweep_once, clock, reset, !clearing, !clearing, "clearing sweep restarted")
   // a written cell's column lies on the screen
   `TTCS_ASSERT(a_cell_col, clock, reset, (!rsp_empty && rsp_data.cell_written) |-> (int'(rsp_data.cell_col) < ttcs_pkg::COLUMNS), "written cell beyond right edge")
   // a write that scrolled lands on the bottom row
   `TTCS_ASSERT(a_scroll_row, clock, reset, (!rsp_empty && rsp_data.cell_written && (rsp_data.rows_scrolled != '0)) |-> (rsp_data.cell_row == BOTTOM_ROW), "scrolled write not on bottom row")
   // nothing is accepted and no result is pending during the sweep
   `TTCS_ASSERT(a_no_accept_sweep, clock, reset, clearing |-> (!accept && rsp_empty), "activity during clearing sweep")

endmodule

`default_nettype wire

// ----- verif/ttcs_screen_checker.sv -----
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the screen and cursor,
// and checks every result beat against the oldest outstanding prediction.
module ttcs_screen_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_push,
   input  wire logic          req_full,
   input  ttcs_pkg::req_type  req_data,
   input  wire logic          rsp_empty,
   input  wire logic          rsp_pop,
   input  ttcs_pkg::rsp_type  rsp_data,
   input  wire logic          csr_wr_en,
   input  wire logic [7:0]    csr_wr_data,
   output int                 error_count,
   output int                 awaited_count,
   output int                 cells_written,
   output int                 scroll_beats
);
   import ttcs_pkg::*;

   logic [15:0]          screen [CELLS];
   logic [ROW_POS_W-1:0] row_now;
   logic [COL_POS_W-1:0] col_now;
   logic [7:0]           colour;
   rsp_type              awaited_q [$];

   function automatic void bump_row();
      if (row_now < ROW_LIMIT)
         row_now = row_now + 1'b1;
   endfunction

   // shift up by n rows (capped at ROWS), blank the freed rows
   function automatic int scroll_screen(input int n);
      int rows;
      rows = (n > ROWS) ? ROWS : n;
      for (int i = 0; i < (ROWS - rows) * COLUMNS; i++)
         screen[i] = screen[i + rows * COLUMNS];
      for (int i = (ROWS - rows) * COLUMNS; i < CELLS; i++)
         screen[i] = {colour, CHAR_SPACE};
      return rows;
   endfunction

   function automatic rsp_type apply_command(input req_type beat);
      rsp_type res;
      int      pos;
      res = '0;
      case (beat.cmd)
         CMD_PUT: begin
            if (beat.char_code == CHAR_NEWLINE) begin
               col_now = '0;
               bump_row();
            end else if (beat.char_code == CHAR_TAB) begin
               pos = int'(col_now) + TAB_STEP - int'(col_now) % TAB_STEP;
               col_now = (pos > COLUMNS) ? COLUMNS : pos;
            end else begin
               if (col_now >= COLUMNS) begin
                  col_now = '0;
                  bump_row();
               end
               if (row_now >= ROWS) begin
                  res.rows_scrolled = scroll_screen(int'(row_now) - ROWS + 1);
                  row_now = ROWS - 1;
               end
               pos = int'(row_now) * COLUMNS + int'(col_now);
               screen[pos] = {colour, beat.char_code};
               res.cell_written = 1'b1;
               res.cell_row = row_now;
               res.cell_col = col_now;
               res.cell_value = {colour, beat.char_code};
               col_now = col_now + 1'b1;
            end
         end
         CMD_CLEAR: res.rows_scrolled = scroll_screen(ROWS);
         CMD_READ: begin
            if (beat.read_row < ROWS && beat.read_col < COLUMNS)
               res.read_value = screen[int'(beat.read_row) * COLUMNS + int'(beat.read_col)];
         end
         default: ;
      endcase
      res.cursor_row = row_now;
      res.cursor_col = col_now;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++)
            screen[i] = CELL_RESET;
         row_now = '0;
         col_now = '0;
         colour = TEXT_COLOR_RESET;
         awaited_q.delete();
         error_count = 0;
         cells_written = 0;
         scroll_beats = 0;
      end else begin
         // compare before taking in a new beat
         if (rsp_pop && !rsp_empty) begin
            if (awaited_q.size() == 0) begin
               $error("result beat with nothing outstanding");
               error_count++;
            end else begin
               want = awaited_q.pop_front();
               check_field("cell_written", want.cell_written, rsp_data.cell_written);
               check_field("cell_row", want.cell_row, rsp_data.cell_row);
               check_field("cell_col", want.cell_col, rsp_data.cell_col);
               check_field("cell_value", want.cell_value, rsp_data.cell_value);
               check_field("rows_scrolled", want.rows_scrolled, rsp_data.rows_scrolled);
               check_field("cursor_row", want.cursor_row, rsp_data.cursor_row);
               check_field("cursor_col", want.cursor_col, rsp_data.cursor_col);
               check_field("read_value", want.read_value, rsp_data.read_value);
            end
         end
         if (req_push && !req_full) begin
            want = apply_command(req_data);
            cells_written += want.cell_written;
            if (want.rows_scrolled != 0)
               scroll_beats++;
            awaited_q.push_back(want);
         end
         if (csr_wr_en)
            colour = csr_wr_data;
      end
      awaited_count <= awaited_q.size();
   end

endmodule

// ----- verif/text_terminal_cursor_scroll_tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict. All prediction and checking lives in the checker.
module text_terminal_cursor_scroll_tb;
   import ttcs_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;   // decoded as a no-op
   localparam int PHASES      = 6;
   localparam int PHASE_BEATS = 310;
   localparam int SETTLE      = 8;
   // every beat a full-screen scroll plus stalls, four times over, plus the sweep
   localparam int unsigned CYCLE_LIMIT =
      4 * ((PHASES * PHASE_BEATS + 64) * (CELLS + 12) + 2 * CELLS);

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [7:0]  csr_wr_data;

   int          errors;
   int          awaited;
   int          written;
   int          scrolls;
   int unsigned cycles = 0;
   int          pop_rest = 0;
   bit          calm = 1'b0;    // set for the final phase: no idling on either side

   text_terminal_cursor_scroll uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ttcs_screen_checker screen_check (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (errors),
      .awaited_count (awaited),
      .cells_written (written),
      .scroll_beats  (scrolls)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung handshake or a lost result ends up here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: pop mostly high, with occasional random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_rest = 0;
      end else if (pop_rest > 0) begin
         pop_rest--;
         rsp_pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         pop_rest = $urandom_range(0, 3);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   function automatic req_type pack_beat(input logic [1:0] cmd, input logic [7:0] ch,
                                         input logic [4:0] row, input logic [6:0] col);
      req_type b;
      b.cmd       = cmd;
      b.char_code = ch;
      b.read_row  = row;
      b.read_col  = col;
      return b;
   endfunction

   // Push stays high on return so back-to-back beats never toggle it
   // within one step; it is only lowered by hold_off or drain.
   task automatic send_beat(input req_type beat);
      req_data <= beat;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      req_push <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // every beat sent has its result back, then a short settle
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (awaited != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_colour(input logic [7:0] c);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      req_type    beat;
      int         pick;
      int         burst;
      int         sent;
      int         total;
      logic [7:0] hue;
      logic [4:0] row;
      logic [6:0] col;

      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      total = 0;

      // ---- directed: reset colour, read bounds, wrap, tab clamp, clear ----
      // reads of the freshly swept store and just outside it on each axis
      send_beat(pack_beat(CMD_READ, 8'h00, 5'd0, 7'd0));
      send_beat(pack_beat(CMD_READ, 8'h00, ROWS - 1, COLUMNS - 1));
      send_beat(pack_beat(CMD_READ, 8'h00, ROWS, 7'd0));
      send_beat(pack_beat(CMD_READ, 8'h00, 5'd0, COLUMNS));
      send_beat(pack_beat(CMD_READ, 8'hFF, 5'h1F, 7'h7F));
      // character extremes, then a newline
      send_beat(pack_beat(CMD_PUT, 8'h41, 5'd0, 7'd0));
      send_beat(pack_beat(CMD_PUT, 8'h00, 5'h1F, 7'h7F));
      send_beat(pack_beat(CMD_PUT, 8'hFF, 5'd0, 7'd0));
      send_beat(pack_beat(CMD_PUT, CHAR_NEWLINE, 5'd0, 7'd0));
      // ten tabs reach the right edge; the eleventh must clamp there
      repeat (11) send_beat(pack_beat(CMD_PUT, CHAR_TAB, 5'd0, 7'd0));
      // printable at the edge wraps to the next row
      send_beat(pack_beat(CMD_PUT, 8'h5A, 5'd0, 7'd0));
      send_beat(pack_beat(CMD_UNUSED, 8'hFF, 5'h1F, 7'h7F));
      send_beat(pack_beat(CMD_READ, 8'h00, 5'd0, 7'd0));
      // clear leaves the cursor; the blank must carry the current colour
      send_beat(pack_beat(CMD_CLEAR, 8'h00, 5'd0, 7'd0));
      send_beat(pack_beat(CMD_READ, 8'h00, 5'd2, 7'd0));
      send_beat(pack_beat(CMD_PUT, 8'h7E, 5'd0, 7'd0));
      total += 26;

      // ---- random phases, one colour each, extremes first ----
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0:       hue = 8'h00;
            1:       hue = 8'hFF;
            2:       hue = 8'h1E;
            default: hue = 8'($urandom);
         endcase
         set_colour(hue);
         calm = (ph == PHASES - 1);
         sent = 0;
         while (sent < PHASE_BEATS) begin
            if (!calm && $urandom_range(0, 5) == 0)
               hold_off($urandom_range(1, 4));
            // in the second phase the sender waits out every outstanding result once, mid-phase
            if (ph == 1 && sent == PHASE_BEATS / 2)
               drain();
            pick = $urandom_range(0, 99);
            beat = pack_beat(CMD_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
            if (pick == 99) begin
               // newline run: drives the row into saturation, big scroll follows
               burst = $urandom_range(2, 40);
               if (burst > PHASE_BEATS - sent)
                  burst = PHASE_BEATS - sent;
               repeat (burst) begin
                  beat.char_code = CHAR_NEWLINE;
                  beat.read_row  = 5'($urandom);
                  send_beat(beat);
               end
               sent += burst;
            end else begin
               if (pick >= 60 && pick < 70) begin
                  beat.char_code = CHAR_NEWLINE;
               end else if (pick >= 70 && pick < 75) begin
                  beat.char_code = CHAR_TAB;
               end else if (pick >= 75 && pick < 96) begin
                  // mostly on-screen reads, some anywhere in the field range
                  row = ($urandom_range(0, 4) == 0) ? 5'($urandom) : $urandom_range(0, ROWS - 1);
                  col = ($urandom_range(0, 4) == 0) ? 7'($urandom)
                                                     : $urandom_range(0, COLUMNS - 1);
                  beat.cmd      = CMD_READ;
                  beat.read_row = row;
                  beat.read_col = col;
               end else if (pick >= 96 && pick < 98) begin
                  beat.cmd = CMD_CLEAR;
               end else if (pick == 98) begin
                  beat.cmd = CMD_UNUSED;
               end
               send_beat(beat);
               sent++;
            end
         end
         total += sent;
      end

      drain();
      // long enough for a full scroll to surface any stray result
      repeat (CELLS + SETTLE) @(posedge clock);

      $display("run covered %0d beats over %0d colour settings", total, PHASES + 1);
      $display("  %0d cells written, %0d beats that scrolled the screen", written, scrolls);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ttcs_pkg.sv
hdl/ttcs_op_queue.sv
hdl/ttcs_front.sv
hdl/ttcs_back.sv
hdl/text_terminal_cursor_scroll.sv
verif/ttcs_screen_checker.sv
verif/text_terminal_cursor_scroll_tb.sv
